FILE: rtl/gbm_pkg.sv
// Package for the 3x3 grid boundary marker.
// Holds register indexes, reset values, neighbourhood mode codes and the
// structs passed between the top level and the decision logic.
package gbm_pkg;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 8;

  localparam logic [CFG_IDX_BITS-1:0] REG_TARGET  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_REPLACE = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BORDER  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MODE    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLS    = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROWS    = 3'd6;

  localparam logic [7:0] RST_TARGET  = 8'd101;
  localparam logic [7:0] RST_REPLACE = 8'd7;
  localparam logic [7:0] RST_BORDER  = 8'd0;
  localparam logic [3:0] RST_LIMIT   = 4'd2;
  localparam logic [1:0] RST_MODE    = 2'd0;
  localparam logic [7:0] RST_COLS    = 8'd128;
  localparam logic [7:0] RST_ROWS    = 8'd128;

  localparam logic [1:0] MODE_EIGHT = 2'd0;
  localparam logic [1:0] MODE_FOUR  = 2'd1;
  localparam logic [1:0] MODE_PAIR  = 2'd2;

  typedef struct packed {
    logic [3:0] limit;
    logic [1:0] mode;
  } rule_t;

  // Where the window centre sits in the grid, worked out at acceptance.
  typedef struct packed {
    logic valid_out;
    logic first_row;
    logic last_row;
    logic first_col;
    logic last_col;
    logic last;
  } pos_flags_t;

endpackage

FILE: rtl/gbm_if.sv
// Handshake channels of the grid boundary marker: input tiles and results.
// Payload types follow the field list; no package dependency.
interface gbm_in_if #(parameter int TILE_BITS = 8);
  logic                 valid;
  logic                 ready;
  logic [TILE_BITS-1:0] tile_in;
  logic                 flush;

  modport source (output valid, output tile_in, output flush, input ready);
  modport sink   (input valid, input tile_in, input flush, output ready);
endinterface

interface gbm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tile_out;
  logic       changed;
  logic       frame_last;

  modport source (output valid, output tile_out, output changed, output frame_last,
                  input ready);
  modport sink   (input valid, input tile_out, input changed, input frame_last,
                  output ready);
endinterface

FILE: rtl/gbm_decide.sv
// Boundary decision for one 3x3 window: border substitution, neighbour
// comparison and the mode test. Uses gbm_pkg for rule and position structs.
module gbm_decide #(
  parameter int TILE_BITS = 8
) (
  input  logic [TILE_BITS-1:0] win [9],
  input  logic [TILE_BITS-1:0] border,
  input  logic [TILE_BITS-1:0] target,
  input  gbm_pkg::rule_t       rule,
  input  gbm_pkg::pos_flags_t  pos,
  output logic                 mark
);
  import gbm_pkg::*;

  logic [TILE_BITS-1:0] m [9];
  logic [TILE_BITS-1:0] ctr;
  logic [2:0]           orth;
  logic [2:0]           diag;
  logic [3:0]           cnt;

  // Window index is row * 3 + column; row 0 is the upper line.
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      m[i] = win[i];
    end
    if (pos.first_row) begin
      m[0] = border; m[1] = border; m[2] = border;
    end
    if (pos.last_row) begin
      m[6] = border; m[7] = border; m[8] = border;
    end
    if (pos.first_col) begin
      m[0] = border; m[3] = border; m[6] = border;
    end
    if (pos.last_col) begin
      m[2] = border; m[5] = border; m[8] = border;
    end
  end

  assign ctr  = m[4];
  assign orth = 3'(m[1] != ctr) + 3'(m[7] != ctr) + 3'(m[3] != ctr) + 3'(m[5] != ctr);
  assign diag = 3'(m[0] != ctr) + 3'(m[2] != ctr) + 3'(m[6] != ctr) + 3'(m[8] != ctr);
  assign cnt  = {1'b0, orth} + {1'b0, diag};

  always_comb begin
    mark = 1'b0;
    if (ctr == target) begin
      case (rule.mode)
        MODE_EIGHT: mark = cnt >= rule.limit;
        MODE_FOUR:  mark = {1'b0, orth} >= rule.limit;
        MODE_PAIR:  mark = ((m[3] != ctr) && (m[5] != ctr)) ||
                           ((m[1] != ctr) && (m[7] != ctr));
        default:    mark = 1'b0;
      endcase
    end
  end

endmodule

FILE: rtl/grid_boundary_marker_3x3.sv
// Streaming 3x3 boundary filter over a row-major tile grid.
// Depends on gbm_pkg, the gbm_in_if / gbm_out_if channels and gbm_decide.
//
// Usage:
//   in_items carries one tile per item in row-major order; after the grid,
//   send grid_cols + 1 items with flush set to drain the last row.
//   out_items returns one result per grid position, for the position one row
//   and one column behind the newest tile; frame_last marks the final one,
//   after which the next item starts a new grid.
//   Configuration is written through cfg_wr_en / cfg_index / cfg_data while
//   the block is idle.
// Timing:
//   One item per clock sustained while the receiver does not stall. A result
//   passes the line memory read stage and then the output register. Both
//   line buffers share one memory whose word holds the upper and middle
//   tile of a column; it is read at acceptance and written back when the
//   read stage moves on, with forwarding for single-column grids.
// Reset clears the counters, the window and the registers to their reset
// values; line memory contents are left as they are. When the receiver
// stalls, the output register holds its item, the read stage holds behind it
// and the input stops only once both are full.
module grid_boundary_marker_3x3 #(
  parameter int MAX_COLS  = 128,
  parameter int MAX_ROWS  = 128,
  parameter int TILE_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  gbm_in_if.sink                              in_items,
  gbm_out_if.source                           out_items,
  input  logic                                cfg_wr_en,
  input  logic [gbm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [gbm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import gbm_pkg::*;

  localparam int CBITS = $clog2(MAX_COLS);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 2);

  // Configuration registers
  logic [7:0] target_tile;
  logic [7:0] replacement_tile;
  logic [7:0] border_tile;
  logic [3:0] match_limit;
  logic [1:0] neighborhood_mode;
  logic [7:0] grid_cols;
  logic [7:0] grid_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_tile       <= RST_TARGET;
      replacement_tile  <= RST_REPLACE;
      border_tile       <= RST_BORDER;
      match_limit       <= RST_LIMIT;
      neighborhood_mode <= RST_MODE;
      grid_cols         <= RST_COLS;
      grid_rows         <= RST_ROWS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TARGET:  target_tile       <= cfg_data;
        REG_REPLACE: replacement_tile  <= cfg_data;
        REG_BORDER:  border_tile       <= cfg_data;
        REG_LIMIT:   match_limit       <= cfg_data[3:0];
        REG_MODE:    neighborhood_mode <= cfg_data[1:0];
        REG_COLS:    grid_cols         <= cfg_data;
        REG_ROWS:    grid_rows         <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [TILE_BITS-1:0] border_t;
  logic [TILE_BITS-1:0] target_t;
  logic [TILE_BITS-1:0] replace_t;
  rule_t                rule;

  assign border_t   = TILE_BITS'(border_tile);
  assign target_t   = TILE_BITS'(target_tile);
  assign replace_t  = TILE_BITS'(replacement_tile);
  assign rule.limit = match_limit;
  assign rule.mode  = neighborhood_mode;

  // Clamp grid size to 1 .. maximum
  logic [CW-1:0] ncols;
  logic [RW-1:0] nrows;
  logic [RW:0]   nrows_p1;

  always_comb begin
    if (grid_cols == '0) begin
      ncols = CW'(1);
    end else if (32'(grid_cols) > 32'(MAX_COLS)) begin
      ncols = CW'(MAX_COLS);
    end else begin
      ncols = CW'(grid_cols);
    end
    if (grid_rows == '0) begin
      nrows = RW'(1);
    end else if (32'(grid_rows) > 32'(MAX_ROWS)) begin
      nrows = RW'(MAX_ROWS);
    end else begin
      nrows = RW'(grid_rows);
    end
  end

  assign nrows_p1 = {1'b0, nrows} + (RW+1)'(1);

  // Position counters of the next incoming tile
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] col_count_next;
  logic [RW-1:0] row_count_next;

  logic [CW-1:0] c_cur;
  logic [RW:0]   r_step;
  logic [RW-1:0] r_cur;
  logic [RW-1:0] rc;
  logic [CW-1:0] cc;
  logic          row_ok;
  logic [CW-1:0] c_inc;
  logic [RW:0]   r_inc;
  pos_flags_t    pos_in;

  always_comb begin
    // Wrap counters left past the end by a size change
    if (col_count >= ncols) begin
      c_cur  = '0;
      r_step = {1'b0, row_count} + (RW+1)'(1);
    end else begin
      c_cur  = col_count;
      r_step = {1'b0, row_count};
    end
    r_cur = (r_step > nrows_p1) ? '0 : r_step[RW-1:0];

    if (c_cur != '0) begin
      rc     = r_cur - RW'(1);
      cc     = c_cur - CW'(1);
      row_ok = (r_cur >= RW'(1)) && (rc < nrows);
    end else begin
      rc     = r_cur - RW'(2);
      cc     = ncols - CW'(1);
      row_ok = (r_cur >= RW'(2)) && (rc < nrows);
    end

    pos_in.valid_out = row_ok;
    pos_in.first_row = rc == '0;
    pos_in.last_row  = rc == nrows - RW'(1);
    pos_in.first_col = cc == '0;
    pos_in.last_col  = cc == ncols - CW'(1);
    pos_in.last      = row_ok && pos_in.last_row && pos_in.last_col;

    c_inc = c_cur + CW'(1);
    r_inc = {1'b0, r_cur} + (RW+1)'(1);
    if (pos_in.last) begin
      col_count_next = '0;
      row_count_next = '0;
    end else if (c_inc >= ncols) begin
      col_count_next = '0;
      row_count_next = (r_inc > nrows_p1) ? '0 : r_inc[RW-1:0];
    end else begin
      col_count_next = c_inc;
      row_count_next = r_cur;
    end
  end

  // Handshake
  logic in_acc;
  logic s1_valid;
  logic s1_go;
  logic out_valid;

  assign s1_go          = !out_valid || out_items.ready;
  assign in_items.ready = !s1_valid || s1_go;
  assign in_acc         = in_items.valid && in_items.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_acc) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // Line memory: word = {upper tile, middle tile} of one column
  logic [2*TILE_BITS-1:0] line_mem [MAX_COLS];
  logic [2*TILE_BITS-1:0] rd_word;
  logic [CBITS-1:0]       rd_addr;
  logic                   wr_en;
  logic [2*TILE_BITS-1:0] wr_word;

  logic [TILE_BITS-1:0]   t_in;
  logic [TILE_BITS-1:0]   s1_tile;
  logic [CBITS-1:0]       s1_addr;
  pos_flags_t             s1_pos;
  logic                   s1_fwd;
  logic [2*TILE_BITS-1:0] s1_fwd_word;
  logic [2*TILE_BITS-1:0] s1_word;
  logic [TILE_BITS-1:0]   top;
  logic [TILE_BITS-1:0]   mid;

  assign rd_addr = c_cur[CBITS-1:0];
  assign t_in    = in_items.flush ? border_t : in_items.tile_in;
  assign wr_en   = s1_valid && s1_go;
  assign wr_word = {mid, s1_tile};

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_word <= line_mem[rd_addr];
    end
    if (wr_en) begin
      line_mem[s1_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_tile     <= t_in;
      s1_addr     <= rd_addr;
      s1_pos      <= pos_in;
      // Read and write-back hit the same column: take the new word directly
      s1_fwd      <= wr_en && (rd_addr == s1_addr);
      s1_fwd_word <= wr_word;
    end
  end

  assign s1_word = s1_fwd ? s1_fwd_word : rd_word;
  assign top     = s1_word[2*TILE_BITS-1:TILE_BITS];
  assign mid     = s1_word[TILE_BITS-1:0];

  // Window: entries 0..2 older column, 3..5 newer column, top to bottom
  logic [TILE_BITS-1:0] win [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (wr_en) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= s1_tile;
    end
  end

  logic [TILE_BITS-1:0] w9 [9];
  logic                 mark;

  assign w9[0] = win[0];
  assign w9[1] = win[3];
  assign w9[2] = top;
  assign w9[3] = win[1];
  assign w9[4] = win[4];
  assign w9[5] = mid;
  assign w9[6] = win[2];
  assign w9[7] = win[5];
  assign w9[8] = s1_tile;

  gbm_decide #(
    .TILE_BITS (TILE_BITS)
  ) u_decide (
    .win    (w9),
    .border (border_t),
    .target (target_t),
    .rule   (rule),
    .pos    (s1_pos),
    .mark   (mark)
  );

  // Output register
  logic [7:0] out_tile;
  logic       out_changed;
  logic       out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= s1_valid && s1_pos.valid_out;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_valid && s1_pos.valid_out) begin
      out_tile    <= 8'(mark ? replace_t : w9[4]);
      out_changed <= mark;
      out_last    <= s1_pos.last;
    end
  end

  assign out_items.valid      = out_valid;
  assign out_items.tile_out   = out_tile;
  assign out_items.changed    = out_changed;
  assign out_items.frame_last = out_last;

endmodule

FILE: rtl/gbm_checker.sv
// Port-level checks for grid_boundary_marker_3x3, attached by bind.
// Sees only the top-level channel signals; no package dependency.
module gbm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_tile,
  input logic       out_changed,
  input logic       out_last
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_tile) && $stable(out_changed) &&
                                $stable(out_last))
    else $error("result payload changed while stalled");

  // A fresh result comes from an item taken earlier, through the read stage
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a matching item");

  // Reset empties the output register
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind grid_boundary_marker_3x3 gbm_checker u_gbm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_items.valid),
  .in_ready    (in_items.ready),
  .out_valid   (out_items.valid),
  .out_ready   (out_items.ready),
  .out_tile    (out_items.tile_out),
  .out_changed (out_items.changed),
  .out_last    (out_items.frame_last)
);

FILE: dv/gbm_boundary_checker.sv
`timescale 1ns / 100ps
// Checker for the 3x3 grid boundary marker: follows register writes and both
// channels, predicts each result and compares it. Needs gbm_pkg and gbm_if.
module gbm_boundary_checker (
  input  logic                              clk,
  input  logic                              rst,
  gbm_in_if                                 in_ch,
  gbm_out_if                                out_ch,
  input  logic                              cfg_wr_en,
  input  logic [gbm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [gbm_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output int                                errors,
  output int                                pending
);
  import gbm_pkg::*;

  localparam int LINE_LEN = 128;
  localparam int ROW_MAX  = 128;
  localparam int SHOW_MAX = 10;

  typedef struct packed {
    logic [7:0] tile;
    logic       changed;
    logic       frame_last;
  } tile_result_t;

  logic [7:0] target_val, replace_val, border_val, cols_val, rows_val;
  logic [3:0] limit_val;
  logic [1:0] mode_val;

  logic [7:0] upper_tiles [LINE_LEN];
  logic [7:0] middle_tiles[LINE_LEN];
  logic [7:0] window[6];
  int         row_pos, col_pos;

  tile_result_t expected_tiles[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Work out the outcome of one tile on the unmodified grid and advance the window.
  function automatic void mark_boundary(input logic [7:0] tile, input logic drain,
                                        output logic produced, output tile_result_t res);
    int         ncols, nrows, c, r, rc, cc, orth, diag;
    logic [7:0] t, top, mid, ctr;
    logic [7:0] w[3][3];
    logic       hit, last;

    ncols = (cols_val == 0) ? 1 : ((cols_val > LINE_LEN) ? LINE_LEN : int'(cols_val));
    nrows = (rows_val == 0) ? 1 : ((rows_val > ROW_MAX) ? ROW_MAX : int'(rows_val));
    if (col_pos >= ncols) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos > nrows + 1) row_pos = 0;
    c = col_pos;
    r = row_pos;

    t   = drain ? border_val : tile;
    top = upper_tiles[c];
    mid = middle_tiles[c];
    if (c >= 1) begin
      rc = r - 1;
      cc = c - 1;
    end else begin
      rc = r - 2;
      cc = ncols - 1;
    end
    produced = (rc >= 0) && (rc < nrows);
    hit  = 1'b0;
    last = 1'b0;
    res  = '0;

    if (produced) begin
      for (int i = 0; i < 3; i++) begin
        w[i][0] = window[i];
        w[i][1] = window[3 + i];
      end
      w[0][2] = top;
      w[1][2] = mid;
      w[2][2] = t;
      // Substitute the border for rows and columns outside the grid
      if (rc == 0) for (int j = 0; j < 3; j++) w[0][j] = border_val;
      if (rc + 1 >= nrows) for (int j = 0; j < 3; j++) w[2][j] = border_val;
      if (cc == 0) for (int i = 0; i < 3; i++) w[i][0] = border_val;
      if (cc + 1 >= ncols) for (int i = 0; i < 3; i++) w[i][2] = border_val;

      ctr = w[1][1];
      if (ctr == target_val) begin
        orth = int'(w[0][1] != ctr) + int'(w[2][1] != ctr)
             + int'(w[1][0] != ctr) + int'(w[1][2] != ctr);
        diag = int'(w[0][0] != ctr) + int'(w[0][2] != ctr)
             + int'(w[2][0] != ctr) + int'(w[2][2] != ctr);
        case (mode_val)
          MODE_EIGHT: hit = (orth + diag) >= limit_val;
          MODE_FOUR:  hit = orth >= limit_val;
          MODE_PAIR:  hit = (w[1][0] != ctr && w[1][2] != ctr)
                         || (w[0][1] != ctr && w[2][1] != ctr);
          default:    hit = 1'b0;
        endcase
      end
      last = (rc == nrows - 1) && (cc == ncols - 1);
      res.tile       = hit ? replace_val : ctr;
      res.changed    = hit;
      res.frame_last = last;
    end

    upper_tiles[c]  = mid;
    middle_tiles[c] = t;
    window[0] = window[3];
    window[1] = window[4];
    window[2] = window[5];
    window[3] = top;
    window[4] = mid;
    window[5] = t;

    if (last) begin
      row_pos = 0;
      col_pos = 0;
    end else begin
      col_pos = c + 1;
      if (col_pos >= ncols) begin
        col_pos = 0;
        row_pos = r + 1;
        if (row_pos > nrows + 1) row_pos = 0;
      end
    end
  endfunction

  task automatic report(input string msg);
    errors++;
    if (errors <= SHOW_MAX) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : track
    tile_result_t got, want;
    logic         produced;

    if (rst) begin
      target_val  = RST_TARGET;
      replace_val = RST_REPLACE;
      border_val  = RST_BORDER;
      limit_val   = RST_LIMIT;
      mode_val    = RST_MODE;
      cols_val    = RST_COLS;
      rows_val    = RST_ROWS;
      for (int i = 0; i < LINE_LEN; i++) begin
        upper_tiles[i]  = '0;
        middle_tiles[i] = '0;
      end
      for (int i = 0; i < 6; i++) window[i] = '0;
      row_pos = 0;
      col_pos = 0;
      expected_tiles.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_TARGET:  target_val  = cfg_data;
          REG_REPLACE: replace_val = cfg_data;
          REG_BORDER:  border_val  = cfg_data;
          REG_LIMIT:   limit_val   = cfg_data[3:0];
          REG_MODE:    mode_val    = cfg_data[1:0];
          REG_COLS:    cols_val    = cfg_data;
          REG_ROWS:    rows_val    = cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        mark_boundary(in_ch.tile_in, in_ch.flush, produced, want);
        if (produced) expected_tiles.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.tile       = out_ch.tile_out;
        got.changed    = out_ch.changed;
        got.frame_last = out_ch.frame_last;
        if (expected_tiles.size() == 0) begin
          report($sformatf("result with none expected: tile %0d changed %0d last %0d",
                           got.tile, got.changed, got.frame_last));
        end else begin
          want = expected_tiles.pop_front();
          if (got !== want)
            report($sformatf({"mismatch: tile exp %0d got %0d, changed exp %0d got %0d, ",
                              "last exp %0d got %0d"}, want.tile, got.tile,
                             want.changed, got.changed, want.frame_last, got.frame_last));
        end
      end
    end
    pending = expected_tiles.size();
  end

endmodule

FILE: dv/tb_grid_boundary_marker_3x3.sv
`timescale 1ns / 100ps
// Top of the grid boundary marker testbench: clock, reset, register writes,
// tile stimulus and result back-pressure. Needs gbm_pkg, gbm_if and the checker.
module tb_grid_boundary_marker_3x3;
  import gbm_pkg::*;

  localparam logic [1:0] MODE_NONE   = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         ITEM_GOAL   = 880;
  localparam int         HOLD_CYCLES = 60;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

  int         errors, pending;
  int         items_sent = 0;
  int unsigned cycle_count = 0;
  bit         quiet = 1'b0;
  bit         hold_off = 1'b0;

  logic [7:0] cur_target, cur_replace, cur_border;
  int         n_cols, n_rows;

  gbm_in_if #(.TILE_BITS(8)) in_ch();
  gbm_out_if                 out_ch();

  grid_boundary_marker_3x3 dut (
    .clk       (clk),
    .rst       (rst),
    .in_items  (in_ch),
    .out_items (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gbm_boundary_checker mon (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always #6 clk = ~clk;

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_grid_boundary_marker_3x3: errors");
    $finish;
  end

  // Result side: short random stalls, and a long hold when asked
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic send_item(input logic [7:0] tile, input logic drain);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.tile_in = tile;
    in_ch.flush   = drain;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Drop valid and wait for every outstanding result, plus the pipeline depth
  task automatic settle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic set_config(input logic [7:0] target, input logic [7:0] repl,
                            input logic [7:0] border, input logic [3:0] limit,
                            input logic [1:0] mode, input logic [7:0] cols,
                            input logic [7:0] rows);
    settle();
    write_reg(REG_TARGET, target);
    write_reg(REG_REPLACE, repl);
    write_reg(REG_BORDER, border);
    write_reg(REG_LIMIT, {4'd0, limit});
    write_reg(REG_MODE, {6'd0, mode});
    write_reg(REG_COLS, cols);
    write_reg(REG_ROWS, rows);
    cur_target  = target;
    cur_replace = repl;
    cur_border  = border;
    n_cols = (cols == 0) ? 1 : ((cols > 128) ? 128 : int'(cols));
    n_rows = (rows == 0) ? 1 : ((rows > 128) ? 128 : int'(rows));
  endtask

  // Lean towards the values that make boundaries
  function automatic logic [7:0] pick_tile();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return cur_target;
      4, 5:       return cur_border;
      6:          return cur_replace;
      default:    return 8'($urandom);
    endcase
  endfunction

  // One whole grid and its drain; noise puts flushes in the grid and tiles in the drain
  task automatic send_frame(input int noise_pct);
    for (int i = 0; i < n_rows * n_cols; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_item(8'($urandom), 1'b1);
      else send_item(pick_tile(), 1'b0);
    end
    for (int i = 0; i <= n_cols; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_item(pick_tile(), 1'b0);
      else send_item(8'($urandom), 1'b1);
    end
  endtask

  task automatic random_config(input logic [7:0] cols, input logic [7:0] rows);
    logic [7:0] target, border;
    logic [3:0] limit;
    logic [1:0] mode;

    case ($urandom_range(0, 5))
      0:       target = 8'h00;
      1:       target = 8'hFF;
      default: target = 8'($urandom);
    endcase
    border = ($urandom_range(0, 3) == 0) ? target : 8'($urandom);
    limit  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(1, 8));
    mode   = ($urandom_range(0, 7) == 0) ? MODE_NONE : 2'($urandom_range(0, 2));
    set_config(target, 8'($urandom), border, limit, mode, cols, rows);
  endtask

  initial begin
    int phase;

    in_ch.valid   = 1'b0;
    in_ch.tile_in = '0;
    in_ch.flush   = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // 3x3 grid, limit zero: every target tile is marked
    set_config(8'hFF, 8'h00, 8'h00, 4'd0, MODE_EIGHT, 8'd3, 8'd3);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    repeat (4) send_item(8'($urandom), 1'b1);

    // Zero sizes act as a single tile; mode three never marks
    set_config(8'h00, 8'hFF, 8'h00, 4'd9, MODE_NONE, 8'd0, 8'd0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b1);

    // Opposite pairs on 2x2, flush inside the grid and a tile in the drain
    set_config(8'h00, 8'h5A, 8'hFF, 4'd8, MODE_PAIR, 8'd2, 8'd2);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h37, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'h11, 1'b1);
    send_item(8'hA5, 1'b0);
    send_item(8'h22, 1'b1);

    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      case (phase)
        3: begin
          // Oversized column count; hold results back until the input stalls
          random_config(8'd200, 8'd1);
          hold_off = 1'b1;
          send_frame(3);
        end
        7: begin
          random_config(8'd1, 8'd255);
          send_frame(3);
        end
        default: begin
          random_config(($urandom_range(0, 10) == 0) ? 8'd0 : 8'($urandom_range(1, 7)),
                        ($urandom_range(0, 10) == 0) ? 8'd0 : 8'($urandom_range(1, 6)));
          repeat ($urandom_range(1, 3)) send_frame(($urandom_range(0, 2) == 0) ? 0 : 5);
        end
      endcase
      phase++;
      if (items_sent > ITEM_GOAL - 120) quiet = 1'b1;
    end

    settle();
    repeat (8) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_grid_boundary_marker_3x3: clean");
    end else begin
      $display("tb_grid_boundary_marker_3x3: errors");
    end
    $finish;
  end

endmodule
